// ----- rtl/core/shcp_pkg.sv -----
// ----------------------------------------------------------------------------
// shcp_pkg
// Shared types and constants of the scan header component parser.
// ----------------------------------------------------------------------------
`default_nettype none

package shcp_pkg;

  // Number of entries in the component id table
  localparam int unsigned TableEntries = 4;
  localparam int unsigned TableIdxW    = 2;
  localparam int unsigned IdW          = 8;
  localparam int unsigned TypeW        = 3;
  localparam int unsigned SelW         = 3;

  // Largest legal selector nibble or type value
  localparam logic [3:0] SelMax  = 4'd4;
  localparam logic [2:0] TypeMax = 3'd4;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Output payload: 51 bits of fields padded to whole bytes
  localparam int unsigned OutDataW = 56;

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhLenLow  = 3'd1,
    PhCount   = 3'd2,
    PhCompId  = 3'd3,
    PhCompSel = 3'd4,
    PhTrail1  = 3'd5,
    PhTrail2  = 3'd6,
    PhTrail3  = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KindEntry   = 2'd0,
    KindTrailer = 2'd1,
    KindInvalid = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCompCount = 2'd0,
    CfgCompIds   = 2'd1,
    CfgCompTypes = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0] approx_low;
    logic [3:0] approx_high;
    logic [7:0] spectral_end;
    logic [7:0] spectral_start;
    logic [7:0] comp_total;
    logic [2:0] type_sel;
    logic [2:0] ac_sel;
    logic [2:0] dc_sel;
    logic [1:0] table_index;
    logic [7:0] comp_pos;
  } result_t;

endpackage : shcp_pkg

`default_nettype wire

// ----- rtl/core/scan_header_component_parser.sv -----
// ----------------------------------------------------------------------------
// scan_header_component_parser
// Byte-serial parser for scan header segments with component id lookup.
// ----------------------------------------------------------------------------
// Takes one header byte per cycle and produces at most one result per byte,
// registered in the cycle after the byte is taken. A byte flagged in tuser
// starts a new segment and drops any segment in progress. Each good
// component gives an entry result; the third trailer byte gives a trailer
// result with tlast; any failed check gives one invalid result with tlast
// and the parser then waits for the next segment start. The id lookup
// compares against every enabled table entry in parallel in the same cycle, so
// the sustained rate is one byte per clock; the output register holds a
// result under backpressure while the input side stalls only if that
// register is full and not being drained. MaxComponents caps how many table
// entries are searched. Configuration is to be written while no segment is
// in flight.
`default_nettype none

module scan_header_component_parser #(
  parameter int unsigned MaxComponents = 4
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [shcp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [shcp_pkg::CfgDataW-1:0]  cfg_data_i,
  // byte stream in
  input  wire logic                           s_axis_tvalid_i,
  output      logic                           s_axis_tready_o,
  input  wire logic [7:0]                     s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic                           s_axis_tuser_i,   // [0] seg_start
  // results out
  output      logic                           m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // [7:0] comp_pos, [9:8] table_index, [12:10] dc_sel, [15:13] ac_sel,
  // [18:16] type_sel, [26:19] comp_total, [34:27] spectral_start,
  // [42:35] spectral_end, [46:43] approx_high, [50:47] approx_low, rest 0
  output      logic [shcp_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output      logic [1:0]                     m_axis_tuser_o,   // [1:0] result_kind
  output      logic                           m_axis_tlast_o    // last
);

  localparam int unsigned PadW = shcp_pkg::OutDataW - $bits(shcp_pkg::result_t);
  // most table entries ever searched
  localparam logic [2:0] TblCap = (MaxComponents < shcp_pkg::TableEntries)
                                  ? 3'(MaxComponents) : 3'(shcp_pkg::TableEntries);

  // configuration
  logic [2:0]  comp_count_q;
  logic [31:0] comp_ids_q;
  logic [11:0] comp_types_q;

  // parser state
  shcp_pkg::phase_e phase_q, phase_d;
  logic [7:0] length_high_q, length_high_d;
  logic [7:0] comps_left_q, comps_left_d;
  logic [7:0] comp_index_q, comp_index_d;
  logic [7:0] total_comps_q, total_comps_d;
  logic [7:0] held_id_q, held_id_d;
  logic [7:0] trail1_q, trail1_d;
  logic [7:0] trail2_q, trail2_d;

  // output register
  logic              out_valid_q, out_valid_d;
  shcp_pkg::result_t out_res_q, out_res_d;
  shcp_pkg::kind_e   out_kind_q, out_kind_d;
  logic              out_last_q, out_last_d;

  logic       in_fire;
  logic       emit;
  logic       bad;
  logic [7:0] b;
  logic [3:0] hi_nib, lo_nib;
  logic [2:0] tbl_lim;
  logic       id_found;
  logic [shcp_pkg::TableIdxW-1:0] id_idx;
  logic [2:0] id_type;
  logic [7:0] comps_left_dec;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign b               = s_axis_tdata_i;
  assign hi_nib          = b[7:4];
  assign lo_nib          = b[3:0];
  assign comps_left_dec  = comps_left_q - 8'd1;
  assign tbl_lim         = (comp_count_q > TblCap) ? TblCap : comp_count_q;

  // parallel id lookup, lowest matching entry wins
  always_comb begin
    id_found = 1'b0;
    id_idx   = '0;
    for (int i = shcp_pkg::TableEntries - 1; i >= 0; i--) begin
      if ((3'(i) < tbl_lim) && (comp_ids_q[i*shcp_pkg::IdW +: shcp_pkg::IdW] == held_id_q)) begin
        id_found = 1'b1;
        id_idx   = shcp_pkg::TableIdxW'(i);
      end
    end
    id_type = comp_types_q[id_idx*shcp_pkg::TypeW +: shcp_pkg::TypeW];
  end

  // next state
  always_comb begin
    phase_d       = phase_q;
    length_high_d = length_high_q;
    comps_left_d  = comps_left_q;
    comp_index_d  = comp_index_q;
    total_comps_d = total_comps_q;
    held_id_d     = held_id_q;
    trail1_d      = trail1_q;
    trail2_d      = trail2_q;
    emit          = 1'b0;
    bad           = 1'b0;
    out_res_d     = '0;
    out_kind_d    = shcp_pkg::KindEntry;
    out_last_d    = 1'b0;
    if (in_fire) begin
      if (s_axis_tuser_i) begin
        length_high_d = b;
        comps_left_d  = '0;
        comp_index_d  = '0;
        total_comps_d = '0;
        phase_d       = shcp_pkg::PhLenLow;
      end else begin
        case (phase_q)
          shcp_pkg::PhLenLow: begin
            if (length_high_q == 8'd0 && b < 8'd2) begin
              bad = 1'b1;
            end else begin
              phase_d = shcp_pkg::PhCount;
            end
          end
          shcp_pkg::PhCount: begin
            total_comps_d = b;
            comps_left_d  = b;
            comp_index_d  = '0;
            phase_d       = (b == 8'd0) ? shcp_pkg::PhTrail1 : shcp_pkg::PhCompId;
          end
          shcp_pkg::PhCompId: begin
            held_id_d = b;
            phase_d   = shcp_pkg::PhCompSel;
          end
          shcp_pkg::PhCompSel: begin
            if (hi_nib <= shcp_pkg::SelMax && lo_nib <= shcp_pkg::SelMax && id_found
                && id_type <= shcp_pkg::TypeMax) begin
              emit                  = 1'b1;
              out_res_d.comp_pos    = comp_index_q;
              out_res_d.table_index = id_idx;
              out_res_d.dc_sel      = hi_nib[2:0];
              out_res_d.ac_sel      = lo_nib[2:0];
              out_res_d.type_sel    = id_type;
              out_res_d.comp_total  = total_comps_q;
              comp_index_d          = comp_index_q + 8'd1;
              comps_left_d          = comps_left_dec;
              phase_d = (comps_left_dec == 8'd0) ? shcp_pkg::PhTrail1 : shcp_pkg::PhCompId;
            end else begin
              bad = 1'b1;
            end
          end
          shcp_pkg::PhTrail1: begin
            trail1_d = b;
            phase_d  = shcp_pkg::PhTrail2;
          end
          shcp_pkg::PhTrail2: begin
            trail2_d = b;
            phase_d  = shcp_pkg::PhTrail3;
          end
          shcp_pkg::PhTrail3: begin
            emit                     = 1'b1;
            out_kind_d               = shcp_pkg::KindTrailer;
            out_last_d               = 1'b1;
            out_res_d.comp_total     = total_comps_q;
            out_res_d.spectral_start = trail1_q;
            out_res_d.spectral_end   = trail2_q;
            out_res_d.approx_high    = hi_nib;
            out_res_d.approx_low     = lo_nib;
            phase_d                  = shcp_pkg::PhIdle;
          end
          default: begin
            // idle: stray bytes are dropped
          end
        endcase
        // a failed check gives an invalid result and ends the segment
        if (bad) begin
          emit                 = 1'b1;
          out_kind_d           = shcp_pkg::KindInvalid;
          out_last_d           = 1'b1;
          out_res_d            = '0;
          out_res_d.comp_pos   = comp_index_q;
          out_res_d.comp_total = total_comps_q;
          phase_d              = shcp_pkg::PhIdle;
        end
      end
    end
  end

  always_comb begin
    if (in_fire && emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_count_q  <= '0;
      comp_ids_q    <= '0;
      comp_types_q  <= '0;
      phase_q       <= shcp_pkg::PhIdle;
      length_high_q <= '0;
      comps_left_q  <= '0;
      comp_index_q  <= '0;
      total_comps_q <= '0;
      held_id_q     <= '0;
      trail1_q      <= '0;
      trail2_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (shcp_pkg::cfg_idx_e'(cfg_idx_i))
          shcp_pkg::CfgCompCount: comp_count_q <= cfg_data_i[2:0];
          shcp_pkg::CfgCompIds:   comp_ids_q   <= cfg_data_i;
          shcp_pkg::CfgCompTypes: comp_types_q <= cfg_data_i[11:0];
          default: begin
          end
        endcase
      end
      phase_q       <= phase_d;
      length_high_q <= length_high_d;
      comps_left_q  <= comps_left_d;
      comp_index_q  <= comp_index_d;
      total_comps_q <= total_comps_d;
      held_id_q     <= held_id_d;
      trail1_q      <= trail1_d;
      trail2_q      <= trail2_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload only loads on a new result
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_res_q  <= out_res_d;
      out_kind_q <= out_kind_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{PadW{1'b0}}, out_res_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // a start byte always moves the parser to the low length byte
  a_start_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tuser_i) |=> (phase_q == shcp_pkg::PhLenLow))
    else $error("start byte did not restart the parser");

  // tlast marks exactly the trailer and invalid results
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_last_q == (out_kind_q != shcp_pkg::KindEntry)))
    else $error("tlast does not match result kind");

  // a pending segment-ending result leaves the parser idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (phase_q == shcp_pkg::PhIdle))
    else $error("parser not idle behind a segment-ending result");

  // entries carry in-range selectors
  a_entry_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == shcp_pkg::KindEntry) |->
      (out_res_q.dc_sel <= 3'd4 && out_res_q.ac_sel <= 3'd4 && out_res_q.type_sel <= 3'd4))
    else $error("entry result with selector out of range");

endmodule : scan_header_component_parser

`default_nettype wire

// ----- verif/tb_scan_header_component_parser.sv -----
// ----------------------------------------------------------------------------
// tb_scan_header_component_parser
// Self-checking bench for the scan header component parser.
// ----------------------------------------------------------------------------
// Segments are built as byte queues: well-formed headers with random content,
// plus short lengths, bad selectors, unknown ids, bad types, restarts and
// stray bytes. A clocked driver sends them in bursts and a clocked monitor
// takes results under a changing stall pattern. Every accepted byte runs
// through a local parser model; each result is checked field by field
// against the oldest predicted one. The id table is rewritten between
// phases, only while the parser is idle.
`timescale 1ns / 100ps

module tb_scan_header_component_parser;

  typedef struct packed {
    shcp_pkg::kind_e   kind;
    logic              last;
    shcp_pkg::result_t f;
  } header_result_t;

  typedef struct {
    logic [7:0] data;
    logic       start;
    bit         drain_first;  // hold this request until all results are in
  } hdr_byte_t;

  typedef enum int {
    FlawNone,
    FlawShortLen,
    FlawBadSel,
    FlawUnknownId,
    FlawBadType,
    FlawRestart
  } seg_flaw_e;

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          cfg_we_i        = 1'b0;
  logic [shcp_pkg::CfgIdxW-1:0]  cfg_idx_i       = '0;
  logic [shcp_pkg::CfgDataW-1:0] cfg_data_i      = '0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [7:0]                    s_axis_tdata_i  = '0;
  logic                          s_axis_tuser_i  = 1'b0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [shcp_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic [1:0]                    m_axis_tuser_o;
  logic                          m_axis_tlast_o;

  scan_header_component_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Table copy used by the parser model
  logic [2:0]  cfg_count = '0;
  logic [31:0] cfg_ids   = '0;
  logic [11:0] cfg_types = '0;

  // Parser model state
  shcp_pkg::phase_e ph  = shcp_pkg::PhIdle;
  logic [7:0]  len_hi   = '0;
  logic [7:0]  left     = '0;
  logic [7:0]  cidx     = '0;
  logic [7:0]  total    = '0;
  logic [7:0]  held_id  = '0;
  logic [7:0]  trail1   = '0;
  logic [7:0]  trail2   = '0;

  header_result_t pending_results[$];
  hdr_byte_t      item_q[$];

  int errors       = 0;
  int bytes_sent   = 0;
  int useful_bytes = 0;
  int n_entry      = 0;
  int n_trailer    = 0;
  int n_invalid    = 0;

  // Feed one accepted header byte through the parser model
  function automatic void predict_header_byte(input logic [7:0] b, input logic start);
    header_result_t r;
    bit             emit;
    bit             bad;
    int             lim;
    int             hit;
    logic [2:0]     ty;
    logic [3:0]     hi;
    logic [3:0]     lo;
    r    = '0;
    emit = 1'b0;
    bad  = 1'b0;
    hi   = b[7:4];
    lo   = b[3:0];
    if (start) begin
      len_hi = b;
      left   = '0;
      cidx   = '0;
      total  = '0;
      ph     = shcp_pkg::PhLenLow;
    end else begin
      case (ph)
        shcp_pkg::PhLenLow: begin
          if ({len_hi, b} < 16'd2) bad = 1'b1;
          else ph = shcp_pkg::PhCount;
        end
        shcp_pkg::PhCount: begin
          total = b;
          left  = b;
          cidx  = '0;
          ph    = (b == 8'd0) ? shcp_pkg::PhTrail1 : shcp_pkg::PhCompId;
        end
        shcp_pkg::PhCompId: begin
          held_id = b;
          ph      = shcp_pkg::PhCompSel;
        end
        shcp_pkg::PhCompSel: begin
          lim = (cfg_count > shcp_pkg::TableEntries) ? shcp_pkg::TableEntries : cfg_count;
          hit = shcp_pkg::TableEntries;
          // lowest matching entry wins
          for (int i = shcp_pkg::TableEntries - 1; i >= 0; i--)
            if (i < lim && cfg_ids[8*i +: 8] == held_id) hit = i;
          if (hi > shcp_pkg::SelMax || lo > shcp_pkg::SelMax
              || hit == shcp_pkg::TableEntries) begin
            bad = 1'b1;
          end else begin
            ty = cfg_types[3*hit +: 3];
            if (ty > shcp_pkg::TypeMax) begin
              bad = 1'b1;
            end else begin
              emit                = 1'b1;
              r.kind              = shcp_pkg::KindEntry;
              r.f.comp_pos        = cidx;
              r.f.table_index     = hit[1:0];
              r.f.dc_sel          = hi[2:0];
              r.f.ac_sel          = lo[2:0];
              r.f.type_sel        = ty;
              r.f.comp_total      = total;
              cidx                = cidx + 8'd1;
              left                = left - 8'd1;
              ph                  = (left == 8'd0) ? shcp_pkg::PhTrail1 : shcp_pkg::PhCompId;
            end
          end
        end
        shcp_pkg::PhTrail1: begin
          trail1 = b;
          ph     = shcp_pkg::PhTrail2;
        end
        shcp_pkg::PhTrail2: begin
          trail2 = b;
          ph     = shcp_pkg::PhTrail3;
        end
        shcp_pkg::PhTrail3: begin
          emit               = 1'b1;
          r.kind             = shcp_pkg::KindTrailer;
          r.last             = 1'b1;
          r.f.comp_total     = total;
          r.f.spectral_start = trail1;
          r.f.spectral_end   = trail2;
          r.f.approx_high    = hi;
          r.f.approx_low     = lo;
          ph                 = shcp_pkg::PhIdle;
        end
        default: ;  // idle: stray byte dropped
      endcase
    end
    if (bad) begin
      emit           = 1'b1;
      r.kind         = shcp_pkg::KindInvalid;
      r.last         = 1'b1;
      r.f.comp_pos   = cidx;
      r.f.comp_total = total;
      ph             = shcp_pkg::PhIdle;
    end
    if (emit) pending_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------- driver
  int        gap_left   = 0;
  int        burst_left = 0;
  hdr_byte_t nxt;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_header_byte(s_axis_tdata_i, s_axis_tuser_i);
        bytes_sent++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (item_q.size() == 0 ||
                     (item_q[0].drain_first && pending_results.size() != 0)) begin
          s_axis_tvalid_i <= 1'b0;
        end else begin
          nxt = item_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= nxt.data;
          s_axis_tuser_i  <= nxt.start;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(40);
            gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------- monitor
  int                rx_mode = 0;
  int                rx_left = 0;
  header_result_t    want_r;
  shcp_pkg::result_t got_r;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(3);
        rx_left = $urandom_range(16, 160);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0:       m_axis_tready_i <= 1'b1;
        1:       m_axis_tready_i <= 1'($urandom_range(1));
        2:       m_axis_tready_i <= ($urandom_range(3) == 0);
        default: m_axis_tready_i <= (rx_left % 6) >= 2;
      endcase
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind 0x%0h data 0x%0h",
                 $time, m_axis_tuser_o, m_axis_tdata_o);
      end else begin
        want_r = pending_results.pop_front();
        got_r  = m_axis_tdata_o[$bits(shcp_pkg::result_t)-1:0];
        check_field("result_kind", want_r.kind, m_axis_tuser_o);
        check_field("last", want_r.last, m_axis_tlast_o);
        check_field("comp_pos", want_r.f.comp_pos, got_r.comp_pos);
        check_field("table_index", want_r.f.table_index, got_r.table_index);
        check_field("dc_sel", want_r.f.dc_sel, got_r.dc_sel);
        check_field("ac_sel", want_r.f.ac_sel, got_r.ac_sel);
        check_field("type_sel", want_r.f.type_sel, got_r.type_sel);
        check_field("comp_total", want_r.f.comp_total, got_r.comp_total);
        check_field("spectral_start", want_r.f.spectral_start, got_r.spectral_start);
        check_field("spectral_end", want_r.f.spectral_end, got_r.spectral_end);
        check_field("approx_high", want_r.f.approx_high, got_r.approx_high);
        check_field("approx_low", want_r.f.approx_low, got_r.approx_low);
        check_field("tdata padding", '0,
                    m_axis_tdata_o[shcp_pkg::OutDataW-1:$bits(shcp_pkg::result_t)]);
        case (want_r.kind)
          shcp_pkg::KindEntry:   n_entry++;
          shcp_pkg::KindTrailer: n_trailer++;
          default:               n_invalid++;
        endcase
      end
    end
  end

  // ------------------------------------------------------------- stimulus
  task automatic push_byte(input logic [7:0] b, input logic start, input bit drain = 1'b0);
    hdr_byte_t it;
    it.data        = b;
    it.start       = start;
    it.drain_first = drain;
    item_q.push_back(it);
  endtask

  // Id from the table: a usable one, one with a bad type, or one not present
  function automatic logic [7:0] pick_comp_id(input seg_flaw_e want);
    int         lim;
    int         i;
    bit         clash;
    logic [7:0] id;
    lim = (cfg_count > shcp_pkg::TableEntries) ? shcp_pkg::TableEntries : cfg_count;
    if (want == FlawUnknownId) begin
      do begin
        id    = 8'($urandom_range(255));
        clash = 1'b0;
        for (int k = 0; k < lim; k++)
          if (cfg_ids[8*k +: 8] == id) clash = 1'b1;
      end while (clash);
      return id;
    end
    if (lim == 0) return 8'($urandom_range(255));
    for (int t = 0; t < 8; t++) begin
      i = $urandom_range(lim - 1);
      if ((want == FlawBadType) == (cfg_types[3*i +: 3] > shcp_pkg::TypeMax))
        return cfg_ids[8*i +: 8];
    end
    return cfg_ids[8*$urandom_range(lim - 1) +: 8];
  endfunction

  task automatic add_segment(input int ncomp, input seg_flaw_e flaw, input bit drain);
    logic [7:0]  seg[$];
    logic [15:0] len;
    logic [7:0]  id;
    logic [7:0]  sel;
    int          flaw_pos;
    int          bad_comp;
    int          n_keep;
    flaw_pos = -1;
    bad_comp = (ncomp > 0) ? $urandom_range(ncomp - 1) : -1;
    if (flaw == FlawShortLen) begin
      len      = 16'($urandom_range(1));
      flaw_pos = 1;
    end else if ($urandom_range(1)) begin
      len = 16'(6 + 2 * ncomp);
    end else begin
      len = 16'($urandom_range(2, 16'hFFFF));
    end
    seg.push_back(len[15:8]);
    seg.push_back(len[7:0]);
    seg.push_back(8'(ncomp));
    for (int c = 0; c < ncomp; c++) begin
      sel[7:4] = 4'($urandom_range(4));
      sel[3:0] = 4'($urandom_range(4));
      id       = pick_comp_id(FlawNone);
      if (c == bad_comp && flaw inside {FlawBadSel, FlawUnknownId, FlawBadType}) begin
        flaw_pos = seg.size() + 1;
        if (flaw == FlawBadSel) begin
          case ($urandom_range(2))
            0:       sel[7:4] = 4'($urandom_range(5, 15));
            1:       sel[3:0] = 4'($urandom_range(5, 15));
            default: sel      = {4'($urandom_range(5, 15)), 4'($urandom_range(5, 15))};
          endcase
        end else begin
          id = pick_comp_id(flaw);
        end
      end
      seg.push_back(id);
      seg.push_back(sel);
    end
    repeat (3) seg.push_back(8'($urandom_range(255)));
    n_keep = seg.size();
    if (flaw == FlawRestart) n_keep = $urandom_range(1, seg.size() - 1);
    else if (flaw_pos >= 0 && $urandom_range(1)) n_keep = flaw_pos + 1;
    for (int i = 0; i < n_keep; i++) push_byte(seg[i], i == 0, drain && i == 0);
    useful_bytes += (flaw_pos >= 0 && flaw_pos < n_keep) ? flaw_pos + 1 : n_keep;
  endtask

  task automatic write_cfg(input shcp_pkg::cfg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      shcp_pkg::CfgCompCount: cfg_count = val[2:0];
      shcp_pkg::CfgCompIds:   cfg_ids   = val;
      default:                cfg_types = val[11:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Parser idle: nothing queued and nothing in flight
  task automatic wait_drained();
    do @(negedge clk_i);
    while (item_q.size() != 0 || s_axis_tvalid_i || pending_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stim
    logic [2:0]  cnt;
    logic [31:0] ids;
    logic [11:0] types;
    int          quota;
    int          r;
    int          ncomp;
    seg_flaw_e   flaw;
    bit          first;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin cnt = 3'd4; ids = 32'h005A00FF; types = 12'h5C4; quota = 330; end
        1: begin cnt = 3'd0; ids = 32'hFFFFFFFF; types = 12'hFFF; quota = 120; end
        2: begin
          cnt   = 3'd4;
          ids   = $urandom;
          for (int i = 0; i < 4; i++) types[3*i +: 3] = 3'($urandom_range(4));
          quota = 700;
        end
        3: begin cnt = 3'd1; ids = 32'h00000000; types = 12'h000; quota = 150; end
        default: begin
          cnt   = 3'd3;
          ids   = $urandom;
          types = 12'($urandom_range(12'hFFF));
          quota = 230;
        end
      endcase
      write_cfg(shcp_pkg::CfgCompCount, {29'd0, cnt});
      write_cfg(shcp_pkg::CfgCompIds, ids);
      write_cfg(shcp_pkg::CfgCompTypes, {20'd0, types});
      useful_bytes = 0;
      if (p == 0) begin
        // table: FF type 4, 00 type 0, 5A type 7, 00 type 2
        push_byte(8'hFF, 1'b0);                          // stray byte while idle
        push_byte(8'h00, 1'b1); push_byte(8'h01, 1'b0);  // length below 2
        push_byte(8'hFF, 1'b1); push_byte(8'hFF, 1'b0);  // max length, no components
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'hF0, 1'b0);
        push_byte(8'h00, 1'b1); push_byte(8'h06, 1'b0);  // abandoned by a restart
        push_byte(8'h00, 1'b1); push_byte(8'h0A, 1'b0); push_byte(8'h03, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'h44, 1'b0);  // top selectors, type 4
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);  // duplicate id, lowest wins
        push_byte(8'h5A, 1'b0); push_byte(8'h12, 1'b0);  // matched entry with bad type
        push_byte(8'h00, 1'b1); push_byte(8'h08, 1'b0); push_byte(8'h01, 1'b0);
        push_byte(8'h33, 1'b0); push_byte(8'h00, 1'b0);  // id not in table
      end
      // one long segment walks comp_pos through all its bits
      if (p == 2) add_segment(255, FlawNone, 1'b0);
      first = 1'b1;
      while (useful_bytes < quota) begin
        if ($urandom_range(15) == 0)
          repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)), 1'b0);
        r = $urandom_range(99);
        if (r < 60)      flaw = FlawNone;
        else if (r < 66) flaw = FlawShortLen;
        else if (r < 75) flaw = FlawBadSel;
        else if (r < 84) flaw = FlawUnknownId;
        else if (r < 90) flaw = FlawBadType;
        else             flaw = FlawRestart;
        ncomp = ($urandom_range(99) < 85) ? $urandom_range(4) : $urandom_range(5, 16);
        add_segment(ncomp, flaw, first || $urandom_range(49) == 0);
        first = 1'b0;
      end
      wait_drained();
    end
    repeat (8) @(posedge clk_i);
    $display("Sent %0d header bytes over 5 table settings, incl. restarts and bad fields.",
             bytes_sent);
    $display("Checked %0d entry, %0d trailer and %0d invalid results.",
             n_entry, n_trailer, n_invalid);
    if (errors == 0) begin
      $display("tb_scan_header_component_parser OK");
    end else begin
      $display("tb_scan_header_component_parser NOT OK");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("tb_scan_header_component_parser NOT OK");
    $finish;
  end

endmodule

// ----- scan_header_component_parser.f -----
rtl/core/shcp_pkg.sv
rtl/core/scan_header_component_parser.sv
verif/tb_scan_header_component_parser.sv
